// ===== rtl/fixed_point_alu_assert.svh =====
// Assertion macros for the checker file.
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define FPA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GE       = 4'd4,
		OP_LE       = 4'd5,
		OP_EQ       = 4'd6,
		OP_NE       = 4'd7,
		OP_MIN      = 4'd8,
		OP_MAX      = 4'd9,
		OP_INC      = 4'd10,
		OP_DEC      = 4'd11,
		OP_FROM_INT = 4'd12,
		OP_TO_INT   = 4'd13
	} op_t;

	// quotient bits resolved in each divider stage
	localparam int DivStepsPerStage = 4;

	// per-request sideband carried alongside the divider
	typedef struct packed {
		logic [31:0] res;
		logic        cmp;
		logic        is_div;
		logic        dz;
		logic        neg;
	} side_t;

endpackage

// ===== rtl/fpa_div_pipe.sv =====
module fpa_div_pipe #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS = 8,
	localparam int NumSteps = WORD_WIDTH + FRAC_BITS,
	localparam int NumStages = (NumSteps + fpa_pkg::DivStepsPerStage - 1)
		/ fpa_pkg::DivStepsPerStage
) (
	input  logic                  clk,
	input  logic [NumStages-1:0]  en,
	input  logic [WORD_WIDTH-1:0] dividend_mag,
	input  logic [WORD_WIDTH-1:0] divisor_mag,
	output logic [WORD_WIDTH-1:0] quotient
);
	import fpa_pkg::*;

	logic [WORD_WIDTH-1:0] rem_s [NumStages];
	logic [WORD_WIDTH-1:0] dvs_s [NumStages];
	logic [NumSteps-1:0]   dq_s  [NumStages];

	for (genvar k = 0; k < NumStages; k++) begin : g_stage
		logic [WORD_WIDTH-1:0] rem_in;
		logic [WORD_WIDTH-1:0] dvs_in;
		logic [NumSteps-1:0]   dq_in;
		logic [WORD_WIDTH-1:0] rem_nx;
		logic [NumSteps-1:0]   dq_nx;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign dvs_in = divisor_mag;
			assign dq_in  = {dividend_mag, FRAC_BITS'(0)};
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign dq_in  = dq_s[k-1];
		end

		// restoring steps: shift in one dividend bit, subtract when it fits
		always_comb begin
			logic [WORD_WIDTH:0] trial;
			logic [WORD_WIDTH:0] diff;
			logic                fits;
			rem_nx = rem_in;
			dq_nx  = dq_in;
			trial  = '0;
			diff   = '0;
			fits   = 1'b0;
			for (int j = 0; j < DivStepsPerStage; j++) begin
				if (k * DivStepsPerStage + j < NumSteps) begin
					trial  = {rem_nx, dq_nx[NumSteps-1]};
					diff   = trial - {1'b0, dvs_in};
					fits   = (trial >= {1'b0, dvs_in});
					rem_nx = fits ? diff[WORD_WIDTH-1:0] : trial[WORD_WIDTH-1:0];
					dq_nx  = {dq_nx[NumSteps-2:0], fits};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= rem_nx;
				dvs_s[k] <= dvs_in;
				dq_s[k]  <= dq_nx;
			end
		end
	end

	assign quotient = dq_s[NumStages-1][WORD_WIDTH-1:0];

endmodule

// ===== rtl/fixed_point_alu.sv =====
// Fixed-point ALU on signed words with FRAC_BITS fractional bits (Q24.8 by default).
// Input channel: in_valid / in_stall carry a request of kind, operand_a and
// operand_b; a request is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry result_value, compare_true and
// divide_by_zero; exactly one result leaves for each request, in order.
// A request passes through the decode stage, the NumDivStages divider stages and
// the output register, where NumDivStages is ceil((WORD_WIDTH + FRAC_BITS) / 4).
// Throughput: one request per cycle while the output is not stalled, set by the
// divider, which resolves four quotient bits per pipeline stage; every other operation rides the same stages.
// Stall: each stage advances when the stage after it is empty or advancing, so
// bubbles close up behind a stalled result and requests keep entering until
// the pipeline is full; a stalled result holds its value.
// Reset: arst_n clears every valid bit at once; the pipeline comes up empty
// and ready to take a request in the first cycle after release.
// Operands use their low WORD_WIDTH bits read as signed; results wrap to
// WORD_WIDTH bits and leave sign-extended to 32 bits.
module fixed_point_alu #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         kind,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic               compare_true,
	output logic               divide_by_zero
);
	import fpa_pkg::*;

	localparam int NumSteps = WORD_WIDTH + FRAC_BITS;
	localparam int NumDivStages = (NumSteps + DivStepsPerStage - 1) / DivStepsPerStage;
	// decode stage, divider stages, output register
	localparam int NumStages = NumDivStages + 2;
	localparam int ProdWidth = 2 * WORD_WIDTH;

	// ---------------------------------------------------------------
	// Flow control: one valid bit per stage, ripple ready from the end
	// ---------------------------------------------------------------
	logic [NumStages-1:0] valid_q;
	logic [NumStages:0]   ready;
	logic [NumStages-1:0] feed;
	logic [NumStages-1:0] load;

	assign ready[NumStages] = !out_stall;
	assign feed[0] = in_valid;

	for (genvar k = 0; k < NumStages; k++) begin : g_flow
		// a stage may take new contents when empty or when its request moves on
		assign ready[k] = !valid_q[k] || ready[k+1];
		if (k > 0) begin : g_feed
			assign feed[k] = valid_q[k-1];
		end
	end

	assign load = ready[NumStages-1:0] & feed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 0; k < NumStages; k++) begin
				if (ready[k]) begin
					valid_q[k] <= feed[k];
				end
			end
		end
	end

	assign in_stall  = !ready[0];
	assign out_valid = valid_q[NumStages-1];

	// ---------------------------------------------------------------
	// Stage 1: decode, simple operations, full product, magnitudes
	// ---------------------------------------------------------------
	logic signed [WORD_WIDTH-1:0] a_w;
	logic signed [WORD_WIDTH-1:0] b_w;
	logic signed [WORD_WIDTH-1:0] simple_w;
	logic                         cmp_w;

	assign a_w = operand_a[WORD_WIDTH-1:0];
	assign b_w = operand_b[WORD_WIDTH-1:0];

	always_comb begin
		simple_w = '0;
		cmp_w    = 1'b0;
		case (kind)
			OP_ADD:      simple_w = a_w + b_w;
			OP_SUB:      simple_w = a_w - b_w;
			OP_GE:       cmp_w = (a_w >= b_w);
			OP_LE:       cmp_w = (a_w <= b_w);
			OP_EQ:       cmp_w = (a_w == b_w);
			OP_NE:       cmp_w = (a_w != b_w);
			// equal operands give operand_a for both
			OP_MIN:      simple_w = (a_w > b_w) ? b_w : a_w;
			OP_MAX:      simple_w = (a_w < b_w) ? b_w : a_w;
			OP_INC:      simple_w = a_w + WORD_WIDTH'(1);
			OP_DEC:      simple_w = a_w - WORD_WIDTH'(1);
			OP_FROM_INT: simple_w = a_w <<< FRAC_BITS;
			OP_TO_INT:   simple_w = a_w >>> FRAC_BITS;
			// multiply and divide finish later; unused codes give zero
			default:     simple_w = '0;
		endcase
	end

	logic                         is_mul_s1;
	logic                         is_div_s1;
	logic                         dz_s1;
	logic                         neg_s1;
	logic                         cmp_s1;
	logic signed [WORD_WIDTH-1:0] simple_s1;
	logic signed [ProdWidth-1:0]  prod_s1;
	logic [WORD_WIDTH-1:0]        a_mag_s1;
	logic [WORD_WIDTH-1:0]        b_mag_s1;

	always_ff @(posedge clk) begin
		if (load[0]) begin
			is_mul_s1 <= (kind == OP_MUL);
			is_div_s1 <= (kind == OP_DIV);
			dz_s1     <= (kind == OP_DIV) && (b_w == '0);
			neg_s1    <= a_w[WORD_WIDTH-1] ^ b_w[WORD_WIDTH-1];
			cmp_s1    <= cmp_w;
			simple_s1 <= simple_w;
			prod_s1   <= ProdWidth'(a_w) * ProdWidth'(b_w);
			// magnitude of the most negative word still fits unsigned
			a_mag_s1  <= a_w[WORD_WIDTH-1] ? WORD_WIDTH'(-a_w) : WORD_WIDTH'(a_w);
			b_mag_s1  <= b_w[WORD_WIDTH-1] ? WORD_WIDTH'(-b_w) : WORD_WIDTH'(b_w);
		end
	end

	// ---------------------------------------------------------------
	// Stage 2 onwards: scale the product, run the divider
	// ---------------------------------------------------------------
	logic signed [ProdWidth+FRAC_BITS-1:0] prod_x;
	logic signed [WORD_WIDTH-1:0]          mul_w;
	logic signed [WORD_WIDTH-1:0]          early_w;

	// widen before the shift so the sign fills every kept bit
	assign prod_x  = (ProdWidth + FRAC_BITS)'(prod_s1);
	assign mul_w   = WORD_WIDTH'(prod_x >>> FRAC_BITS);
	assign early_w = is_mul_s1 ? mul_w : simple_s1;

	logic [WORD_WIDTH-1:0] quotient;

	fpa_div_pipe #(
		.WORD_WIDTH(WORD_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk         (clk),
		.en          (load[NumDivStages:1]),
		.dividend_mag(a_mag_s1),
		.divisor_mag (b_mag_s1),
		.quotient    (quotient)
	);

	// sideband held beside each divider stage
	side_t side_s [NumDivStages];

	always_ff @(posedge clk) begin
		if (load[1]) begin
			side_s[0] <= '{res: 32'(early_w), cmp: cmp_s1, is_div: is_div_s1,
				dz: dz_s1, neg: neg_s1};
		end
		for (int j = 1; j < NumDivStages; j++) begin
			if (load[j+1]) begin
				side_s[j] <= side_s[j-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// Output register: sign the quotient, drop it on a zero divisor
	// ---------------------------------------------------------------
	side_t                        last;
	logic signed [WORD_WIDTH-1:0] quo_signed;

	assign last       = side_s[NumDivStages-1];
	assign quo_signed = last.neg ? WORD_WIDTH'(-quotient) : WORD_WIDTH'(quotient);

	always_ff @(posedge clk) begin
		if (load[NumStages-1]) begin
			if (last.is_div) begin
				result_value <= last.dz ? '0 : 32'(quo_signed);
			end else begin
				result_value <= last.res;
			end
			compare_true   <= last.cmp;
			divide_by_zero <= last.dz;
		end
	end

endmodule

// ===== rtl/fpa_checker.sv =====
`include "fixed_point_alu_assert.svh"

module fpa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] result_value,
	input logic               compare_true,
	input logic               divide_by_zero
);

	logic [33:0] out_word;
	logic        dz_clear;

	assign out_word = {result_value, compare_true, divide_by_zero};
	assign dz_clear = (result_value == 32'sd0) && !compare_true;

	`FPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

	`FPA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word), "stalled result changed")

	// an empty output register means no stage can be blocked
	`FPA_ASSERT_SAME(a_empty_no_stall, !out_valid, !in_stall, "input stalled with output empty")

	`FPA_ASSERT_SAME(a_dz_zero, out_valid && divide_by_zero, dz_clear, "zero divisor result not clear")

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);
